// ===== sv/bmhq_pkg.sv =====
// shared types and constants for the binary min-heap priority queue
// no dependencies; the interfaces, the sequencer and the top refer to this package by scoped names
package bmhq_pkg;

    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int ENTRY_W  = KEY_W + TAG_W;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LARGER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADSLOT = 3'd4;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [SLOT_W-1:0]       slot;
    } request_t;

    typedef struct packed {
        logic                    done;
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [COUNT_W-1:0]      count;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_RD_ROOT,
        S_EX_RD_LAST,
        S_EX_TAKE,
        S_DN_CHK,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DK_RD,
        S_DK_CMP,
        S_FIN
    } state_t;

endpackage

// ===== sv/bmhq_req_if.sv =====
// request channel of the heap queue: valid/ready plus command payload
// depends on bmhq_pkg for field widths
interface bmhq_req_if;
    logic                              valid;
    logic                              ready;
    logic [bmhq_pkg::CMD_W-1:0]        cmd;
    logic signed [bmhq_pkg::KEY_W-1:0] key_value;
    logic [bmhq_pkg::TAG_W-1:0]        entry_tag;
    logic [bmhq_pkg::SLOT_W-1:0]       slot_index;

    modport source (output valid, cmd, key_value, entry_tag, slot_index, input ready);
    modport sink (input valid, cmd, key_value, entry_tag, slot_index, output ready);
endinterface

// ===== sv/bmhq_rsp_if.sv =====
// result channel of the heap queue: valid/ready plus result payload
// depends on bmhq_pkg for field widths
interface bmhq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [bmhq_pkg::STATUS_W-1:0]     status;
    logic signed [bmhq_pkg::KEY_W-1:0] out_key;
    logic [bmhq_pkg::TAG_W-1:0]        out_tag;
    logic [bmhq_pkg::COUNT_W-1:0]      entry_count;

    modport source (output valid, status, out_key, out_tag, entry_count, input ready);
    modport sink (input valid, status, out_key, out_tag, entry_count, output ready);
endinterface

// ===== sv/bmhq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bmhq_seq.sv =====
// heap sequencer: state machine, moving-entry registers and one shared key comparator
// depends on bmhq_pkg and bmhq_ram
module bmhq_seq #(
    parameter int HEAP_SLOTS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bmhq_pkg::request_t req,
    output logic               idle,
    input  logic               res_free,
    output bmhq_pkg::result_t  res
);

    localparam int AW = $clog2(HEAP_SLOTS);
    localparam int SW = (AW > bmhq_pkg::SLOT_W) ? AW : bmhq_pkg::SLOT_W;
    localparam logic [AW-1:0] CAP_C = AW'(HEAP_SLOTS - 1);
    localparam logic [AW-1:0] ROOT_C = AW'(1);

    bmhq_pkg::state_t state_reg, state_next;

    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    cpos_reg, cpos_next;
    bmhq_pkg::entry_t item_reg, item_next;
    bmhq_pkg::entry_t child_reg, child_next;
    logic [bmhq_pkg::STATUS_W-1:0]     st_reg, st_next;
    logic signed [bmhq_pkg::KEY_W-1:0] rkey_reg, rkey_next;
    logic [bmhq_pkg::TAG_W-1:0]        rtag_reg, rtag_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    bmhq_pkg::entry_t             ram_wdata;
    logic [bmhq_pkg::ENTRY_W-1:0] ram_rdata;
    bmhq_pkg::entry_t             rd_entry;

    logic signed [bmhq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic lt;

    logic [AW:0] left_pos, right_pos, cnt_ext;
    logic [SW-1:0] slot_ext, cnt_slot;
    logic is_full, is_empty, slot_bad, at_root, no_left, has_right;

    bmhq_ram #(
        .WIDTH (bmhq_pkg::ENTRY_W),
        .DEPTH (HEAP_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    assign left_pos  = {pos_reg, 1'b0};
    assign right_pos = {pos_reg, 1'b1};
    assign cnt_ext   = {1'b0, cnt_reg};
    assign slot_ext  = SW'(req.slot);
    assign cnt_slot  = SW'(cnt_reg);
    assign is_full   = (cnt_reg == CAP_C);
    assign is_empty  = (cnt_reg == '0);
    assign slot_bad  = (slot_ext == '0) || (slot_ext > cnt_slot);
    assign at_root   = (pos_reg == ROOT_C);
    assign no_left   = (left_pos > cnt_ext);
    assign has_right = (right_pos <= cnt_ext);

    // the one comparator; operands depend on which step is running
    always_comb
    begin
        cmp_a = item_reg.key;
        cmp_b = rd_entry.key;
        case (state_reg)
            bmhq_pkg::S_UP_CMP:
            begin
                cmp_a = item_reg.key;
                cmp_b = rd_entry.key;
            end
            bmhq_pkg::S_DK_CMP:
            begin
                cmp_a = rd_entry.key;
                cmp_b = item_reg.key;
            end
            bmhq_pkg::S_DN_RDR:
            begin
                cmp_a = rd_entry.key;
                cmp_b = child_reg.key;
            end
            bmhq_pkg::S_DN_CMP:
            begin
                cmp_a = child_reg.key;
                cmp_b = item_reg.key;
            end
            default:
            begin
                cmp_a = item_reg.key;
                cmp_b = rd_entry.key;
            end
        endcase
    end

    assign lt = (cmp_a < cmp_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (req.cmd)
                        bmhq_pkg::CMD_INSERT:
                            state_next = is_full ? bmhq_pkg::S_FIN : bmhq_pkg::S_UP_CHK;
                        bmhq_pkg::CMD_EXTRACT:
                            state_next = is_empty ? bmhq_pkg::S_FIN : bmhq_pkg::S_EX_RD_ROOT;
                        bmhq_pkg::CMD_DECREASE:
                            state_next = (is_empty || slot_bad) ? bmhq_pkg::S_FIN
                                                                : bmhq_pkg::S_DK_RD;
                        default:
                            state_next = bmhq_pkg::S_FIN;
                    endcase
                end
            end
            bmhq_pkg::S_UP_CHK:
                state_next = at_root ? bmhq_pkg::S_FIN : bmhq_pkg::S_UP_CMP;
            bmhq_pkg::S_UP_CMP:
                state_next = lt ? bmhq_pkg::S_UP_CHK : bmhq_pkg::S_FIN;
            bmhq_pkg::S_EX_RD_ROOT:
                state_next = bmhq_pkg::S_EX_RD_LAST;
            bmhq_pkg::S_EX_RD_LAST:
                state_next = bmhq_pkg::S_EX_TAKE;
            bmhq_pkg::S_EX_TAKE:
                state_next = bmhq_pkg::S_DN_CHK;
            bmhq_pkg::S_DN_CHK:
                state_next = no_left ? bmhq_pkg::S_FIN : bmhq_pkg::S_DN_RDL;
            bmhq_pkg::S_DN_RDL:
                state_next = has_right ? bmhq_pkg::S_DN_RDR : bmhq_pkg::S_DN_CMP;
            bmhq_pkg::S_DN_RDR:
                state_next = bmhq_pkg::S_DN_CMP;
            bmhq_pkg::S_DN_CMP:
                state_next = lt ? bmhq_pkg::S_DN_CHK : bmhq_pkg::S_FIN;
            bmhq_pkg::S_DK_RD:
                state_next = bmhq_pkg::S_DK_CMP;
            bmhq_pkg::S_DK_CMP:
                state_next = lt ? bmhq_pkg::S_FIN : bmhq_pkg::S_UP_CHK;
            bmhq_pkg::S_FIN:
                state_next = res_free ? bmhq_pkg::S_IDLE : bmhq_pkg::S_FIN;
            default:
                state_next = bmhq_pkg::S_IDLE;
        endcase
    end

    // ram control and result
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = item_reg;
        ram_raddr  = pos_reg;
        idle       = (state_reg == bmhq_pkg::S_IDLE);
        res.done   = 1'b0;
        res.status = st_reg;
        res.key    = rkey_reg;
        res.tag    = rtag_reg;
        res.count  = cnt_slot[bmhq_pkg::COUNT_W-1:0];
        case (state_reg)
            bmhq_pkg::S_UP_CHK:
            begin
                if (at_root)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = pos_reg >> 1;
                end
            end
            bmhq_pkg::S_UP_CMP:
            begin
                // parent moves down into the hole, or the entry settles here
                ram_we = 1'b1;
                if (lt)
                begin
                    ram_wdata = rd_entry;
                end
            end
            bmhq_pkg::S_EX_RD_ROOT:
                ram_raddr = ROOT_C;
            bmhq_pkg::S_EX_RD_LAST:
                ram_raddr = cnt_reg;
            bmhq_pkg::S_DN_CHK:
            begin
                if (no_left)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = left_pos[AW-1:0];
                end
            end
            bmhq_pkg::S_DN_RDL:
                ram_raddr = right_pos[AW-1:0];
            bmhq_pkg::S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (lt)
                begin
                    ram_wdata = child_reg;
                end
            end
            bmhq_pkg::S_DK_RD:
                ram_raddr = pos_reg;
            bmhq_pkg::S_FIN:
                res.done = res_free;
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        cpos_next  = cpos_reg;
        item_next  = item_reg;
        child_next = child_reg;
        st_next    = st_reg;
        rkey_next  = rkey_reg;
        rtag_next  = rtag_reg;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    st_next   = bmhq_pkg::ST_OK;
                    rkey_next = '0;
                    rtag_next = '0;
                    case (req.cmd)
                        bmhq_pkg::CMD_INSERT:
                        begin
                            if (is_full)
                            begin
                                st_next = bmhq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cnt_next       = cnt_reg + AW'(1);
                                pos_next       = cnt_reg + AW'(1);
                                item_next.key  = req.key;
                                item_next.tag  = req.tag;
                                rkey_next      = req.key;
                                rtag_next      = req.tag;
                            end
                        end
                        bmhq_pkg::CMD_EXTRACT:
                        begin
                            if (is_empty)
                            begin
                                st_next = bmhq_pkg::ST_EMPTY;
                            end
                        end
                        bmhq_pkg::CMD_DECREASE:
                        begin
                            if (is_empty)
                            begin
                                st_next = bmhq_pkg::ST_EMPTY;
                            end
                            else if (slot_bad)
                            begin
                                st_next = bmhq_pkg::ST_BADSLOT;
                            end
                            else
                            begin
                                pos_next      = slot_ext[AW-1:0];
                                item_next.key = req.key;
                            end
                        end
                        default:
                        begin
                            st_next = bmhq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bmhq_pkg::S_UP_CMP:
            begin
                if (lt)
                begin
                    pos_next = pos_reg >> 1;
                end
            end
            bmhq_pkg::S_EX_RD_LAST:
            begin
                rkey_next = rd_entry.key;
                rtag_next = rd_entry.tag;
            end
            bmhq_pkg::S_EX_TAKE:
            begin
                item_next = rd_entry;
                cnt_next  = cnt_reg - AW'(1);
                pos_next  = ROOT_C;
            end
            bmhq_pkg::S_DN_RDL:
            begin
                child_next = rd_entry;
                cpos_next  = left_pos[AW-1:0];
            end
            bmhq_pkg::S_DN_RDR:
            begin
                // right child wins only when strictly smaller than the left
                if (lt)
                begin
                    child_next = rd_entry;
                    cpos_next  = right_pos[AW-1:0];
                end
            end
            bmhq_pkg::S_DN_CMP:
            begin
                if (lt)
                begin
                    pos_next = cpos_reg;
                end
            end
            bmhq_pkg::S_DK_CMP:
            begin
                if (lt)
                begin
                    st_next = bmhq_pkg::ST_LARGER;
                end
                else
                begin
                    rkey_next     = rd_entry.key;
                    rtag_next     = rd_entry.tag;
                    item_next.tag = rd_entry.tag;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmhq_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        cpos_reg  <= cpos_next;
        item_reg  <= item_next;
        child_reg <= child_next;
        st_reg    <= st_next;
        rkey_reg  <= rkey_next;
        rtag_reg  <= rtag_next;
    end

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmhq_pkg::S_IDLE) |-> !ram_we)
        else $error("heap ram written while idle");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_C)
        else $error("entry count above capacity");

    a_sift_up_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bmhq_pkg::S_UP_CMP && lt) |=> (pos_reg == ($past(pos_reg) >> 1)))
        else $error("sift up did not move to parent");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bmhq_pkg::S_IDLE && state_reg != bmhq_pkg::S_EX_TAKE)
            |=> $stable(cnt_reg))
        else $error("entry count changed outside its update points");

    a_done_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> (state_reg == bmhq_pkg::S_FIN))
        else $error("result issued outside finish step");

endmodule

// ===== sv/binary_min_heap_queue.sv =====
// channel   dir  payload                                   handshake
// req       in   cmd, key_value, entry_tag, slot_index     valid/ready
// rsp       out  status, out_key, out_tag, entry_count     valid/ready
//
// one request at a time; ready is high only while the sequencer is idle
// insert, decrease: check and compare steps per level climbed; errors go to finish
// extract: root and last reads, then check, left read, right read if any, compare per level
// reset clears state, count, out valid only; heap slots are written before they are read
// the sequencer holds in its finish step while the output register is full and not taken
// depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if, bmhq_seq
module binary_min_heap_queue #(
    parameter int HEAP_SLOTS = 32
) (
    input logic        clk,
    input logic        rst_n,
    bmhq_req_if.sink   req,
    bmhq_rsp_if.source rsp
);

    bmhq_pkg::request_t seq_req;
    bmhq_pkg::result_t  seq_res;
    logic               seq_idle;
    logic               res_free;
    logic               start;

    logic                              out_valid_reg;
    logic [bmhq_pkg::STATUS_W-1:0]     status_reg;
    logic signed [bmhq_pkg::KEY_W-1:0] key_reg;
    logic [bmhq_pkg::TAG_W-1:0]        tag_reg;
    logic [bmhq_pkg::COUNT_W-1:0]      count_reg;

    assign seq_req.cmd  = req.cmd;
    assign seq_req.key  = req.key_value;
    assign seq_req.tag  = req.entry_tag;
    assign seq_req.slot = req.slot_index;

    assign req.ready = seq_idle;
    assign start     = req.valid && seq_idle;
    assign res_free  = !out_valid_reg || rsp.ready;

    bmhq_seq #(
        .HEAP_SLOTS (HEAP_SLOTS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (seq_req),
        .idle     (seq_idle),
        .res_free (res_free),
        .res      (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (seq_res.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_res.done)
        begin
            status_reg <= seq_res.status;
            key_reg    <= seq_res.key;
            tag_reg    <= seq_res.tag;
            count_reg  <= seq_res.count;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_key     = key_reg;
    assign rsp.out_tag     = tag_reg;
    assign rsp.entry_count = count_reg;

endmodule
